// File: design/bpfa_pkg.sv
// Shared types and constants for the bitmap page frame allocator.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package bpfa_pkg;

    // Field widths fixed by the interface
    localparam int TYPE_W   = 3;
    localparam int IDX_W    = 10;
    localparam int TOTAL_W  = 11;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;

    // Parameter defaults
    localparam int MAX_PAGES_DEF     = 1024;
    localparam int MAP_WORD_BITS_DEF = 64;

    // Total page register after reset
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 11'd1024;

    // Request kinds
    localparam logic [TYPE_W-1:0] REQ_ALLOC     = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_FREE      = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_LOCK      = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_RESERVE   = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_UNRESERVE = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STS_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STS_NO_CHANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STS_NO_FREE   = 2'd2;
    localparam logic [STATUS_W-1:0] STS_RANGE     = 2'd3;

    // Controller states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RMW
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic word_clear;  // reset the word counter
        logic word_inc;    // advance the word counter
        logic clr_wr;      // write a zero word at the word counter
        logic latch_req;   // capture the incoming request
        logic rd_in;       // read the word the incoming request needs
        logic rd_next;     // read the word after the word counter
        logic scan;        // evaluate one word of the allocate scan
        logic rmw;         // finish a single-page update
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic last_word;   // word counter at the last map word
        logic in_alloc;    // incoming request is an allocate
        logic scan_done;   // allocate scan ends in this cycle
    } t_dp_sts;

endpackage

`default_nettype wire

// File: design/bpfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bpfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: design/bpfa_ctrl.sv
// Sequencing state machine of the page frame allocator.
// Depends on bpfa_pkg; drives the datapath through t_dp_cmd.
`default_nettype none

module bpfa_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire bpfa_pkg::t_dp_sts i_sts,
    output bpfa_pkg::t_dp_cmd      o_cmd
);
    import bpfa_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register; reset starts the map clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr   = 1'b1;
                o_cmd.word_inc = 1'b1;
                if (i_sts.last_word) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.latch_req  = 1'b1;
                    o_cmd.rd_in      = 1'b1;
                    o_cmd.word_clear = 1'b1;
                    n_state = i_sts.in_alloc ? S_SCAN : S_RMW;
                end
            end
            S_SCAN: begin
                o_cmd.scan    = 1'b1;
                o_cmd.rd_next = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.word_inc = 1'b1;
                end
            end
            S_RMW: begin
                o_cmd.rmw = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/bpfa_dp.sv
// Datapath of the page frame allocator: page map RAM, counters, total
// register and result registers. Depends on bpfa_pkg and bpfa_ram.
`default_nettype none

module bpfa_dp #(
    parameter int MAX_PAGES     = bpfa_pkg::MAX_PAGES_DEF,
    parameter int MAP_WORD_BITS = bpfa_pkg::MAP_WORD_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [bpfa_pkg::TOTAL_W-1:0]   i_cfg_wr_data,
    input  wire logic [bpfa_pkg::TYPE_W-1:0]    i_req_type,
    input  wire logic [bpfa_pkg::IDX_W-1:0]     i_page_index,
    input  wire bpfa_pkg::t_dp_cmd              i_cmd,
    output bpfa_pkg::t_dp_sts                   o_sts,
    output logic                                o_result_valid,
    output logic      [bpfa_pkg::STATUS_W-1:0]  o_status,
    output logic      [bpfa_pkg::IDX_W-1:0]     o_granted_page,
    output logic      [bpfa_pkg::COUNT_W-1:0]   o_used_pages,
    output logic      [bpfa_pkg::COUNT_W-1:0]   o_reserved_pages,
    output logic      [bpfa_pkg::COUNT_W-1:0]   o_free_pages
);
    import bpfa_pkg::*;

    // MAP_WORD_BITS is a power of two: page index splits into word and bit
    localparam int MAP_WORDS = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(MAP_WORD_BITS);
    localparam int EW        = (AW + BIT_W + 1 > 12) ? AW + BIT_W + 1 : 12;
    // Counters run wide: a clear that finds the other counter at zero leaves
    // this one counted, so repeated set/clear pairs can push it past the map
    localparam int TALLY_W   = 32;
    localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);
    localparam logic [EW-1:0] MAX_EW    = EW'(MAX_PAGES);
    localparam logic [EW-1:0] WORD_EW   = EW'(MAP_WORD_BITS);

    logic [TOTAL_W-1:0]       r_total;
    logic [AW-1:0]            r_word;
    logic [TYPE_W-1:0]        r_kind;
    logic [IDX_W-1:0]         r_idx;
    logic [TALLY_W-1:0]       r_used;
    logic [TALLY_W-1:0]       r_rsvd;
    logic                     r_res_vld;
    logic [STATUS_W-1:0]      r_res_status;
    logic [IDX_W-1:0]         r_res_granted;
    logic [COUNT_W-1:0]       r_res_free;

    logic [TALLY_W-1:0]       n_used;
    logic [TALLY_W-1:0]       n_rsvd;
    logic                     n_res_vld;
    logic [STATUS_W-1:0]      n_res_status;
    logic [IDX_W-1:0]         n_res_granted;

    logic [EW-1:0]            eff_total;
    logic [EW-1:0]            scan_start;
    logic [EW-1:0]            scan_rem;
    logic                     scan_in_range;
    logic [MAP_WORD_BITS-1:0] scan_mask;
    logic [MAP_WORD_BITS-1:0] scan_cand;
    logic [BIT_W-1:0]         scan_pos;
    logic                     scan_found;
    logic [BIT_W-1:0]         rmw_bit;
    logic                     rmw_taken;
    logic                     rmw_want;
    logic                     rmw_in_range;
    logic [TALLY_W-1:0]       sum_cnt;
    logic [TALLY_W-1:0]       total_cnt;
    logic [TALLY_W-1:0]       free_cnt;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [MAP_WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]            ram_raddr;
    logic [MAP_WORD_BITS-1:0] ram_rdata;

    bpfa_ram #(
        .WIDTH (MAP_WORD_BITS),
        .DEPTH (MAP_WORDS),
        .AW    (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Clamp the configured total to the map capacity
    assign eff_total = (EW'(r_total) > MAX_EW) ? MAX_EW : EW'(r_total);

    // Allocate scan: mask off pages at or above the total, find lowest clear
    assign scan_start    = EW'(r_word) << BIT_W;
    assign scan_in_range = scan_start < eff_total;
    assign scan_rem      = eff_total - scan_start;

    always_comb begin
        for (int b = 0; b < MAP_WORD_BITS; b++) begin
            scan_mask[b] = EW'(b) < scan_rem;
        end
    end

    assign scan_cand  = ~ram_rdata & scan_mask;
    assign scan_found = scan_in_range && (|scan_cand);

    always_comb begin
        scan_pos = '0;
        for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
            if (scan_cand[b]) begin
                scan_pos = BIT_W'(b);
            end
        end
    end

    // Single-page update terms
    assign rmw_bit      = r_idx[BIT_W-1:0];
    assign rmw_taken    = ram_rdata[rmw_bit];
    assign rmw_want     = (r_kind == REQ_LOCK) || (r_kind == REQ_RESERVE);
    assign rmw_in_range = EW'(r_idx) < eff_total;

    // Status to the controller
    assign o_sts.last_word = r_word == LAST_WORD;
    assign o_sts.in_alloc  = i_req_type == REQ_ALLOC;
    assign o_sts.scan_done = scan_found || !scan_in_range || (scan_rem <= WORD_EW);

    // Memory ports, counter updates and result
    always_comb begin
        ram_we        = 1'b0;
        ram_waddr     = r_word;
        ram_wdata     = '0;
        ram_raddr     = r_word;
        n_used        = r_used;
        n_rsvd        = r_rsvd;
        n_res_vld     = 1'b0;
        n_res_status  = STS_NO_CHANGE;
        n_res_granted = '0;

        if (i_cmd.rd_in) begin
            ram_raddr = o_sts.in_alloc ? '0 : AW'(i_page_index >> BIT_W);
        end else if (i_cmd.rd_next) begin
            ram_raddr = r_word + AW'(1);
        end

        if (i_cmd.clr_wr) begin
            ram_we = 1'b1;
        end

        if (i_cmd.scan && o_sts.scan_done) begin
            n_res_vld = 1'b1;
            if (scan_found) begin
                ram_we        = 1'b1;
                ram_wdata     = ram_rdata | (MAP_WORD_BITS'(1) << scan_pos);
                n_used        = r_used + TALLY_W'(1);
                n_res_status  = STS_DONE;
                n_res_granted = IDX_W'(scan_start + EW'(scan_pos));
            end else begin
                n_res_status = STS_NO_FREE;
            end
        end

        if (i_cmd.rmw) begin
            n_res_vld = 1'b1;
            ram_waddr = AW'(r_idx >> BIT_W);
            if (r_kind == REQ_ALLOC || r_kind > REQ_UNRESERVE) begin
                n_res_status = STS_NO_CHANGE;
            end else if (!rmw_in_range) begin
                n_res_status = STS_RANGE;
            end else if (rmw_taken == rmw_want) begin
                n_res_status = STS_NO_CHANGE;
            end else begin
                ram_we       = 1'b1;
                n_res_status = STS_DONE;
                if (rmw_want) begin
                    ram_wdata = ram_rdata | (MAP_WORD_BITS'(1) << rmw_bit);
                end else begin
                    ram_wdata = ram_rdata & ~(MAP_WORD_BITS'(1) << rmw_bit);
                end
                unique case (r_kind)
                    REQ_FREE:    n_used = (r_used == '0) ? '0 : r_used - TALLY_W'(1);
                    REQ_LOCK:    n_used = r_used + TALLY_W'(1);
                    REQ_RESERVE: n_rsvd = r_rsvd + TALLY_W'(1);
                    default:     n_rsvd = (r_rsvd == '0) ? '0 : r_rsvd - TALLY_W'(1);
                endcase
            end
        end
    end

    // Free pages after the update, floored at zero
    assign sum_cnt   = n_used + n_rsvd;
    assign total_cnt = TALLY_W'(eff_total);
    assign free_cnt  = (sum_cnt >= total_cnt) ? '0 : total_cnt - sum_cnt;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= TOTAL_RESET;
            r_word    <= '0;
            r_used    <= '0;
            r_rsvd    <= '0;
            r_res_vld <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_total <= i_cfg_wr_data;
            end
            if (i_cmd.word_clear) begin
                r_word <= '0;
            end else if (i_cmd.word_inc) begin
                r_word <= r_word + AW'(1);
            end
            r_used    <= n_used;
            r_rsvd    <= n_rsvd;
            r_res_vld <= n_res_vld;
        end
    end

    // Request and result payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_kind <= i_req_type;
            r_idx  <= i_page_index;
        end
        if (n_res_vld) begin
            r_res_status  <= n_res_status;
            r_res_granted <= n_res_granted;
            r_res_free    <= COUNT_W'(free_cnt);
        end
    end

    assign o_result_valid   = r_res_vld;
    assign o_status         = r_res_status;
    assign o_granted_page   = r_res_granted;
    assign o_used_pages     = r_used[COUNT_W-1:0];
    assign o_reserved_pages = r_rsvd[COUNT_W-1:0];
    assign o_free_pages     = r_res_free;

endmodule

`default_nettype wire

// File: design/bitmap_page_frame_allocator_top.sv
// Bitmap page frame allocator, first fit: controller plus datapath.
// Depends on bpfa_pkg, bpfa_ctrl, bpfa_dp (and bpfa_ram through bpfa_dp).
//
// A request is taken when start is high and busy is low. Its result appears
// on the o_ ports for exactly one cycle, marked by o_result_valid; the
// receiver cannot stall it. After reset the block clears its page map, one
// map word per cycle, and holds busy high meanwhile. Free, lock, reserve
// and unreserve read the map word, then write it back if the page changes.
// An allocate reads the map RAM one word per cycle from the lowest page
// upward, examining at least one word and at most
// ceil(min(total, MAX_PAGES) / MAP_WORD_BITS) words. busy drops in
// the cycle the result is shown, so a new request may be given then.
// total_pages may be written only while the block is idle. MAP_WORD_BITS
// must be a power of two.
`default_nettype none

module bitmap_page_frame_allocator_top #(
    parameter int MAX_PAGES     = bpfa_pkg::MAX_PAGES_DEF,
    parameter int MAP_WORD_BITS = bpfa_pkg::MAP_WORD_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [bpfa_pkg::TOTAL_W-1:0]  i_cfg_wr_data,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [bpfa_pkg::TYPE_W-1:0]   i_req_type,
    input  wire logic [bpfa_pkg::IDX_W-1:0]    i_page_index,
    output logic                               o_result_valid,
    output logic      [bpfa_pkg::STATUS_W-1:0] o_status,
    output logic      [bpfa_pkg::IDX_W-1:0]    o_granted_page,
    output logic      [bpfa_pkg::COUNT_W-1:0]  o_used_pages,
    output logic      [bpfa_pkg::COUNT_W-1:0]  o_reserved_pages,
    output logic      [bpfa_pkg::COUNT_W-1:0]  o_free_pages
);
    import bpfa_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    bpfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    bpfa_dp #(
        .MAX_PAGES     (MAX_PAGES),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_req_type       (i_req_type),
        .i_page_index     (i_page_index),
        .i_cmd            (dp_cmd),
        .o_sts            (dp_sts),
        .o_result_valid   (o_result_valid),
        .o_status         (o_status),
        .o_granted_page   (o_granted_page),
        .o_used_pages     (o_used_pages),
        .o_reserved_pages (o_reserved_pages),
        .o_free_pages     (o_free_pages)
    );

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_page_frame_allocator_top (first-fit page allocator).
// Depends on bpfa_pkg and the allocator RTL; a scoreboard class predicts every result word.

module testbench;

    import bpfa_pkg::*;

    localparam int          MAX_PAGES    = MAX_PAGES_DEF;
    localparam int          MAX_GAP      = 8;
    localparam int          SETTLE_TICKS = 40;
    localparam int unsigned CYCLE_LIMIT  = 600000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    granted;
        logic [COUNT_W-1:0]  used;
        logic [COUNT_W-1:0]  reserved;
        logic [COUNT_W-1:0]  free;
    } t_page_reply;

    // Shadow of the page map and counters; predicts one result word per request word
    class frame_map_scoreboard;
        bit [MAX_PAGES-1:0] taken;
        int unsigned        used_cnt;
        int unsigned        reserved_cnt;
        logic [TOTAL_W-1:0] total_reg;
        t_page_reply        awaited[$];
        int                 failures;
        int                 requests;
        int                 grants;
        int                 refusals;
        int                 range_hits;
        int                 no_ops;

        function new();
            taken        = '0;
            used_cnt     = 0;
            reserved_cnt = 0;
            total_reg    = TOTAL_RESET;
            failures     = 0;
            requests     = 0;
            grants       = 0;
            refusals     = 0;
            range_hits   = 0;
            no_ops       = 0;
        endfunction

        function void set_total(logic [TOTAL_W-1:0] value);
            total_reg = value;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Apply one request to the shadow map and queue the result it must produce
        function void note_request(logic [TYPE_W-1:0] kind, logic [IDX_W-1:0] idx);
            int unsigned eff;
            int unsigned sum;
            int unsigned i;
            bit          found;
            bit          want;
            t_page_reply rep;
            eff = (total_reg > MAX_PAGES) ? MAX_PAGES : total_reg;
            rep = '0;
            rep.status = STS_NO_CHANGE;
            found = 1'b0;
            case (kind)
                REQ_ALLOC: begin
                    rep.status = STS_NO_FREE;
                    for (i = 0; i < eff && !found; i++) begin
                        if (!taken[i]) begin
                            taken[i]    = 1'b1;
                            used_cnt++;
                            rep.granted = i[IDX_W-1:0];
                            rep.status  = STS_DONE;
                            found       = 1'b1;
                        end
                    end
                end
                REQ_FREE, REQ_LOCK, REQ_RESERVE, REQ_UNRESERVE: begin
                    want = (kind == REQ_LOCK) || (kind == REQ_RESERVE);
                    if (idx >= eff) begin
                        rep.status = STS_RANGE;
                    end else if (taken[idx] != want) begin
                        taken[idx] = want;
                        rep.status = STS_DONE;
                        case (kind)
                            REQ_FREE:    if (used_cnt != 0) used_cnt--;
                            REQ_LOCK:    used_cnt++;
                            REQ_RESERVE: reserved_cnt++;
                            default:     if (reserved_cnt != 0) reserved_cnt--;
                        endcase
                    end
                end
                default: rep.status = STS_NO_CHANGE;
            endcase
            sum          = used_cnt + reserved_cnt;
            rep.used     = used_cnt[COUNT_W-1:0];
            rep.reserved = reserved_cnt[COUNT_W-1:0];
            rep.free     = (sum >= eff) ? '0 : COUNT_W'(eff - sum);
            case (rep.status)
                STS_DONE:    if (kind == REQ_ALLOC) grants++;
                STS_NO_FREE: refusals++;
                STS_RANGE:   range_hits++;
                default:     no_ops++;
            endcase
            requests++;
            awaited.push_back(rep);
        endfunction

        // Compare one result word against the oldest prediction
        function void check_reply(t_page_reply got);
            t_page_reply want;
            if (awaited.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("[%0t] result word with no request waiting: sts=%0d pg=%0d",
                             $realtime, got.status, got.granted);
            end else begin
                want = awaited.pop_front();
                if (got !== want) begin
                    failures++;
                    if (failures <= 10) begin
                        $write("[%0t] mismatch exp sts=%0d pg=%0d used=%0d rsv=%0d free=%0d",
                               $realtime, want.status, want.granted, want.used,
                               want.reserved, want.free);
                        $display(" | got sts=%0d pg=%0d used=%0d rsv=%0d free=%0d",
                                 got.status, got.granted, got.used, got.reserved,
                                 got.free);
                    end
                end
            end
        endfunction
    endclass

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_wr_en   = 1'b0;
    logic [TOTAL_W-1:0] i_cfg_wr_data = '0;
    logic               start         = 1'b0;
    logic [TYPE_W-1:0]  i_req_type    = '0;
    logic [IDX_W-1:0]   i_page_index  = '0;
    logic               busy;
    logic               o_result_valid;
    logic [STATUS_W-1:0] o_status;
    logic [IDX_W-1:0]   o_granted_page;
    logic [COUNT_W-1:0] o_used_pages;
    logic [COUNT_W-1:0] o_reserved_pages;
    logic [COUNT_W-1:0] o_free_pages;

    frame_map_scoreboard sb = new();
    bit                  no_gaps      = 1'b0;
    int                  total_writes = 0;
    int unsigned         cycle_count  = 0;

    bitmap_page_frame_allocator_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .start            (start),
        .busy             (busy),
        .i_req_type       (i_req_type),
        .i_page_index     (i_page_index),
        .o_result_valid   (o_result_valid),
        .o_status         (o_status),
        .o_granted_page   (o_granted_page),
        .o_used_pages     (o_used_pages),
        .o_reserved_pages (o_reserved_pages),
        .o_free_pages     (o_free_pages)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Sample both handshakes on the edge; the result is checked before the new request is noted
    always @(posedge i_clk) begin
        t_page_reply seen;
        if (i_rst_n) begin
            if (o_result_valid !== 1'b0) begin
                seen = {o_status, o_granted_page, o_used_pages, o_reserved_pages, o_free_pages};
                sb.check_reply(seen);
            end
            if (start && busy === 1'b0)
                sb.note_request(i_req_type, i_page_index);
        end
    end

    // Offer one request word after a random idle gap, hold it until accepted
    task automatic drive_word(logic [TYPE_W-1:0] kind, logic [IDX_W-1:0] idx);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            start        <= 1'b0;
            i_req_type   <= TYPE_W'($urandom);
            i_page_index <= IDX_W'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_req_type   <= kind;
        i_page_index <= idx;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Hold off new requests until every predicted result has arrived
    task automatic drain_replies();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0 || busy !== 1'b0) @(posedge i_clk);
    endtask

    // Write the page total while the block is idle
    task automatic write_total(logic [TOTAL_W-1:0] value);
        drain_replies();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_total(value);
        total_writes++;
    endtask

    // Random requests: mostly valid pages near the allocation front, some noise
    task automatic run_random_phase(logic [TOTAL_W-1:0] total, int count);
        int                unsigned eff;
        int                unsigned span;
        int                alloc_weight;
        int                pick;
        logic [TYPE_W-1:0] kind;
        logic [IDX_W-1:0]  idx;
        write_total(total);
        eff          = (total > MAX_PAGES) ? MAX_PAGES : total;
        span         = (eff > 96) ? 96 : eff;
        alloc_weight = (eff <= 200) ? 45 : 35;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
            pick = $urandom_range(0, 99);
            if (pick < alloc_weight)
                kind = REQ_ALLOC;
            else if (pick < 95)
                kind = TYPE_W'($urandom_range(REQ_FREE, REQ_UNRESERVE));
            else
                kind = TYPE_W'($urandom_range(5, 7));
            pick = $urandom_range(0, 9);
            if (pick == 0 || eff == 0)
                idx = IDX_W'($urandom_range(0, MAX_PAGES - 1));
            else if (pick == 1)
                idx = IDX_W'((eff < MAX_PAGES) ? eff : MAX_PAGES - 1);
            else if (pick < 6)
                idx = IDX_W'($urandom_range(0, span - 1));
            else
                idx = IDX_W'($urandom_range(0, eff - 1));
            drive_word(kind, idx);
            if ($urandom_range(0, 99) == 0) drain_replies();
        end
    endtask

    // Stop a hung run
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycle_count, sb.pending());
        $display("FAIL");
        $finish;
    end

    initial begin
        logic [TOTAL_W-1:0] phase_totals[9];
        int                 phase_items[9];
        phase_totals = '{11'd2047, 11'd64, 11'd1, 11'd65, 11'd0, 11'd1024, 11'd130,
                         11'd1, 11'd1500};
        phase_items  = '{260, 220, 120, 220, 40, 300, 260, 240, 240};
        phase_totals[7] = TOTAL_W'($urandom_range(2, MAX_PAGES));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: first fit, repeated ops, index extremes, cross-counter clears
        drive_word(REQ_ALLOC, 10'h3FF);
        drive_word(REQ_ALLOC, 10'h155);
        drive_word(REQ_FREE, 10'd0);
        drive_word(REQ_FREE, 10'd0);
        drive_word(REQ_ALLOC, 10'h2AA);
        drive_word(REQ_LOCK, 10'd1023);
        drive_word(REQ_LOCK, 10'd1023);
        drive_word(REQ_RESERVE, 10'd512);
        drive_word(REQ_RESERVE, 10'd512);
        drive_word(REQ_UNRESERVE, 10'd512);
        drive_word(REQ_UNRESERVE, 10'd512);
        drive_word(REQ_FREE, 10'd1023);
        drive_word(REQ_RESERVE, 10'd5);
        drive_word(REQ_FREE, 10'd5);
        drive_word(REQ_LOCK, 10'd6);
        drive_word(REQ_UNRESERVE, 10'd6);
        drive_word(REQ_LOCK, 10'd7);
        drive_word(REQ_UNRESERVE, 10'd7);
        drive_word(3'd5, 10'h3FF);
        drive_word(3'd6, 10'd0);
        drive_word(3'd7, 10'd1);
        // Tiny total: map full, then index past the total
        write_total(11'd2);
        drive_word(REQ_ALLOC, 10'd0);
        drive_word(REQ_FREE, 10'd2);
        // No pages managed at all
        write_total(11'd0);
        drive_word(REQ_ALLOC, 10'd0);
        drive_word(REQ_LOCK, 10'd0);
        // Total above capacity clamps to the map size
        write_total(11'd2047);
        drive_word(REQ_LOCK, 10'd1023);

        foreach (phase_totals[p])
            run_random_phase(phase_totals[p], phase_items[p]);

        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);

        $display("Ran %0d requests across %0d page-total writes in %0d cycles",
                 sb.requests, total_writes, cycle_count);
        $display("Outcomes: %0d grants, %0d full-map refusals, %0d out of range, %0d no-ops",
                 sb.grants, sb.refusals, sb.range_hits, sb.no_ops);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("Mismatches: %0d, results missing: %0d", sb.failures, sb.pending());
            $display("FAIL");
        end
        $finish;
    end

endmodule
